@@ rtl/kta_pkg.sv @@
// shared types, register codes and reset values for the keystroke timing anomaly detector
package kta_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FAST_MS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FAST_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIM_TOL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIM_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_HISTORY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HELD_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EJECT_EN     = 3'd6;

    // register reset values
    localparam logic [9:0] RST_FAST_MS     = 10'd12;
    localparam logic [3:0] RST_FAST_LIMIT  = 4'd8;
    localparam logic [9:0] RST_SIM_TOL     = 10'd5;
    localparam logic [3:0] RST_SIM_LIMIT   = 4'd5;
    localparam logic [3:0] RST_MIN_HISTORY = 4'd5;
    localparam logic [7:0] RST_HELD_LIMIT  = 8'd3;
    localparam logic       RST_EJECT_EN    = 1'b0;

    localparam logic [15:0] INTERVAL_SAT = 16'hFFFF;
    localparam logic [7:0]  REPEAT_SAT   = 8'hFF;

    typedef struct packed {
        logic [9:0] fast_interval_ms;
        logic [3:0] fast_count_limit;
        logic [9:0] similar_tolerance_ms;
        logic [3:0] similar_count_limit;
        logic [3:0] min_history;
        logic [7:0] held_repeat_limit;
        logic       eject_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic issue;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic walk_last;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/kta_ctrl.sv @@
// controller state machine: accept, slot update, window walk, result hand-off
module kta_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  kta_pkg::sts_t  sts,
    output kta_pkg::cmd_t  cmd
);
    import kta_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read lands in the accumulators here
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/kta_datapath.sv @@
// datapath: per-slot state, interval history memory, window accumulators, result register
module kta_datapath #(
    parameter int DEVICE_SLOTS  = 4,
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kta_pkg::cmd_t       cmd,
    output kta_pkg::sts_t       sts,
    input  kta_pkg::cfg_t       cfg,
    input  logic [1:0]          s_device_slot,
    input  logic [7:0]          s_key_code,
    input  logic [31:0]         s_time_ms,
    input  logic                m_ready,
    output logic                m_valid,
    output logic                m_suspicious,
    output logic [3:0]          m_fast_count,
    output logic                m_regular_timing,
    output logic                m_eject_request,
    output logic [15:0]         m_interval_ms,
    output logic [7:0]          m_repeat_count
);
    import kta_pkg::*;

    localparam int SW        = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam int IW        = $clog2(HISTORY_DEPTH);
    localparam int FW        = $clog2(HISTORY_DEPTH + 1);
    localparam int MEM_DEPTH = 2 ** (SW + IW);

    // captured item
    logic [SW-1:0]  slot_reg;
    logic [7:0]     key_reg;
    logic [31:0]    time_reg;

    // per-slot state
    logic [31:0]    last_time_reg [DEVICE_SLOTS];
    logic           seen_reg      [DEVICE_SLOTS];
    logic [7:0]     last_key_reg  [DEVICE_SLOTS];
    logic [7:0]     rep_cnt_reg   [DEVICE_SLOTS];
    logic [FW-1:0]  fill_reg      [DEVICE_SLOTS];
    logic [IW-1:0]  head_reg      [DEVICE_SLOTS];

    // interval history, one ring of HISTORY_DEPTH per slot
    logic [15:0]    hist_mem [MEM_DEPTH];
    logic [15:0]    rd_data_reg;
    logic           rd_pend_reg;

    // walk state
    logic [15:0]    iv_reg;
    logic [7:0]     rep_reg;
    logic           check_reg;
    logic [FW-1:0]  n_reg;
    logic [IW-1:0]  ptr_reg;
    logic [FW-1:0]  walk_cnt_reg;
    logic [FW-1:0]  fast_cnt_reg;
    logic [FW-1:0]  sim_cnt_reg;
    logic [15:0]    prev_reg;
    logic           first_reg;

    // result register
    logic           m_valid_reg;
    logic           sus_reg;
    logic [3:0]     fast_out_reg;
    logic           regular_reg;
    logic           eject_reg;
    logic [15:0]    iv_out_reg;
    logic [7:0]     rep_out_reg;

    logic [SW-1:0]  slot_wrapped;
    logic [31:0]    diff;
    logic [15:0]    iv_new;
    logic [7:0]     rep_new;
    logic           full;
    logic [IW-1:0]  wr_idx;
    logic [FW-1:0]  fill_new;
    logic [IW-1:0]  head_new;
    logic [IW-1:0]  head_inc;
    logic [IW-1:0]  ptr_inc;
    logic [15:0]    abs_diff;
    logic           is_fast;
    logic           is_similar;
    logic           regular;
    logic           suspicious;

    // slot number wraps modulo the slot count, at most three subtractions
    always_comb begin
        logic [4:0] v;
        v = {3'b000, s_device_slot};
        for (int k = 0; k < 3; k++) begin
            if (v >= 5'(DEVICE_SLOTS)) begin
                v = v - 5'(DEVICE_SLOTS);
            end
        end
        slot_wrapped = v[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            slot_reg <= slot_wrapped;
            key_reg  <= s_key_code;
            time_reg <= s_time_ms;
        end
    end

    // interval, repeat count and ring position for the captured slot
    always_comb begin
        diff   = time_reg - last_time_reg[slot_reg];
        iv_new = (!seen_reg[slot_reg] || (diff[31:16] != 16'd0)) ? INTERVAL_SAT : diff[15:0];
        if (key_reg == last_key_reg[slot_reg]) begin
            rep_new = (rep_cnt_reg[slot_reg] != REPEAT_SAT)
                      ? rep_cnt_reg[slot_reg] + 8'd1 : rep_cnt_reg[slot_reg];
        end else begin
            rep_new = 8'd0;
        end
        full     = (fill_reg[slot_reg] == FW'(HISTORY_DEPTH));
        head_inc = (head_reg[slot_reg] == IW'(HISTORY_DEPTH - 1))
                   ? '0 : head_reg[slot_reg] + IW'(1);
        wr_idx   = full ? head_reg[slot_reg] : fill_reg[slot_reg][IW-1:0];
        fill_new = full ? fill_reg[slot_reg] : fill_reg[slot_reg] + FW'(1);
        head_new = full ? head_inc : head_reg[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEVICE_SLOTS; i++) begin
                last_time_reg[i] <= '0;
                seen_reg[i]      <= 1'b0;
                last_key_reg[i]  <= '0;
                rep_cnt_reg[i]   <= '0;
                fill_reg[i]      <= '0;
                head_reg[i]      <= '0;
            end
        end else if (cmd.update) begin
            for (int i = 0; i < DEVICE_SLOTS; i++) begin
                if (SW'(i) == slot_reg) begin
                    last_time_reg[i] <= time_reg;
                    seen_reg[i]      <= 1'b1;
                    last_key_reg[i]  <= key_reg;
                    rep_cnt_reg[i]   <= rep_new;
                    fill_reg[i]      <= fill_new;
                    head_reg[i]      <= head_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            hist_mem[{slot_reg, wr_idx}] <= iv_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_data_reg <= hist_mem[{slot_reg, ptr_reg}];
        end
    end

    // window walk, oldest entry first
    always_comb begin
        ptr_inc    = (ptr_reg == IW'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + IW'(1);
        abs_diff   = (rd_data_reg > prev_reg) ? rd_data_reg - prev_reg : prev_reg - rd_data_reg;
        is_fast    = rd_data_reg < {6'd0, cfg.fast_interval_ms};
        is_similar = !first_reg && (abs_diff <= {6'd0, cfg.similar_tolerance_ms});
        sts.walk_last = (walk_cnt_reg == n_reg - FW'(1));
        sts.out_free  = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg  <= 1'b0;
            n_reg        <= '0;
            walk_cnt_reg <= '0;
            fast_cnt_reg <= '0;
            sim_cnt_reg  <= '0;
            first_reg    <= 1'b1;
        end else begin
            rd_pend_reg <= cmd.issue;
            if (cmd.update) begin
                iv_reg       <= iv_new;
                rep_reg      <= rep_new;
                check_reg    <= rep_new < cfg.held_repeat_limit;
                n_reg        <= fill_new;
                ptr_reg      <= head_new;
                walk_cnt_reg <= '0;
                fast_cnt_reg <= '0;
                sim_cnt_reg  <= '0;
                first_reg    <= 1'b1;
            end else begin
                if (cmd.issue) begin
                    ptr_reg      <= ptr_inc;
                    walk_cnt_reg <= walk_cnt_reg + FW'(1);
                end
                if (rd_pend_reg) begin
                    fast_cnt_reg <= fast_cnt_reg + FW'(is_fast);
                    sim_cnt_reg  <= sim_cnt_reg + FW'(is_similar);
                    prev_reg     <= rd_data_reg;
                    first_reg    <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        regular    = check_reg && (8'(n_reg) >= 8'(cfg.min_history))
                     && (8'(sim_cnt_reg) >= 8'(cfg.similar_count_limit));
        suspicious = check_reg
                     && ((8'(fast_cnt_reg) >= 8'(cfg.fast_count_limit)) || regular);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            sus_reg      <= suspicious;
            fast_out_reg <= 4'(fast_cnt_reg);
            regular_reg  <= regular;
            eject_reg    <= suspicious && cfg.eject_enable;
            iv_out_reg   <= iv_reg;
            rep_out_reg  <= rep_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_suspicious     = sus_reg;
    assign m_fast_count     = fast_out_reg;
    assign m_regular_timing = regular_reg;
    assign m_eject_request  = eject_reg;
    assign m_interval_ms    = iv_out_reg;
    assign m_repeat_count   = rep_out_reg;

`ifndef SYNTHESIS
    a_fast_within_window: assert property (@(posedge aclk) disable iff (!aresetn)
        fast_cnt_reg <= n_reg)
        else $error("fast count exceeds window fill");

    a_pairs_within_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (sim_cnt_reg < n_reg) || (sim_cnt_reg == '0))
        else $error("similar pair count exceeds window pairs");

    a_no_read_at_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !rd_pend_reg && !cmd.issue)
        else $error("result formed with a history read outstanding");

    a_walk_covers_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (walk_cnt_reg == n_reg))
        else $error("window walk did not cover the whole fill");
`endif

endmodule

@@ rtl/keystroke_timing_anomaly_detector.sv @@
// top level: configuration registers, controller and datapath
// after an item is accepted the controller runs the slot update, a walk over the slot's window
// at one history read per cycle, a drain step and the emit step, after which m_valid is registered;
// a new item is taken only once the result is handed off; a result held off by m_ready adds its wait
// reset: synchronous active-low aresetn restores register defaults and clears per-slot state;
// history memory is not cleared, entries are only read after being written
module keystroke_timing_anomaly_detector #(
    parameter int DEVICE_SLOTS  = 4,
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [kta_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [kta_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_device_slot,
    input  logic [7:0]                        s_key_code,
    input  logic [31:0]                       s_time_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_suspicious,
    output logic [3:0]                        m_fast_count,
    output logic                              m_regular_timing,
    output logic                              m_eject_request,
    output logic [15:0]                       m_interval_ms,
    output logic [7:0]                        m_repeat_count
);
    import kta_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_interval_ms     <= RST_FAST_MS;
            cfg_reg.fast_count_limit     <= RST_FAST_LIMIT;
            cfg_reg.similar_tolerance_ms <= RST_SIM_TOL;
            cfg_reg.similar_count_limit  <= RST_SIM_LIMIT;
            cfg_reg.min_history          <= RST_MIN_HISTORY;
            cfg_reg.held_repeat_limit    <= RST_HELD_LIMIT;
            cfg_reg.eject_enable         <= RST_EJECT_EN;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_FAST_MS:     cfg_reg.fast_interval_ms     <= cfg_wdata;
                CFG_IDX_FAST_LIMIT:  cfg_reg.fast_count_limit     <= cfg_wdata[3:0];
                CFG_IDX_SIM_TOL:     cfg_reg.similar_tolerance_ms <= cfg_wdata;
                CFG_IDX_SIM_LIMIT:   cfg_reg.similar_count_limit  <= cfg_wdata[3:0];
                CFG_IDX_MIN_HISTORY: cfg_reg.min_history          <= cfg_wdata[3:0];
                CFG_IDX_HELD_LIMIT:  cfg_reg.held_repeat_limit    <= cfg_wdata[7:0];
                CFG_IDX_EJECT_EN:    cfg_reg.eject_enable         <= cfg_wdata[0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    kta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kta_datapath #(
        .DEVICE_SLOTS  (DEVICE_SLOTS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg              (cfg_reg),
        .s_device_slot    (s_device_slot),
        .s_key_code       (s_key_code),
        .s_time_ms        (s_time_ms),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_suspicious     (m_suspicious),
        .m_fast_count     (m_fast_count),
        .m_regular_timing (m_regular_timing),
        .m_eject_request  (m_eject_request),
        .m_interval_ms    (m_interval_ms),
        .m_repeat_count   (m_repeat_count)
    );

endmodule
